// ----- rtl/m4vt_pkg.sv -----
package m4vt_pkg;

  localparam int WORD_W     = 32;
  localparam int COEF_REG_W = 2 * WORD_W;
  localparam int NUM_REGS   = 8;
  localparam int REG_SEL_W  = $clog2(NUM_REGS);
  localparam int CFG_IDX_W  = REG_SEL_W + 1;
  localparam int NUM_LANES  = 4;
  localparam int NUM_COLS   = 4;
  localparam int NUM_PAIRS  = NUM_COLS / 2;
  localparam int Q_SHIFT    = 16;
  localparam int PROD_W     = 2 * WORD_W;
  localparam int PAIR_W     = PROD_W + 1;
  localparam int SUM_W      = PROD_W + 2;
  // multiply, pair add, final add, saturate/output
  localparam int PIPE_DEPTH = 4;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [COEF_REG_W-1:0]    coef_reg_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // register map
  localparam logic [REG_SEL_W-1:0] REG_ROW0_COLS01 = REG_SEL_W'(0);
  localparam logic [REG_SEL_W-1:0] REG_ROW0_COLS23 = REG_SEL_W'(1);
  localparam logic [REG_SEL_W-1:0] REG_ROW1_COLS01 = REG_SEL_W'(2);
  localparam logic [REG_SEL_W-1:0] REG_ROW1_COLS23 = REG_SEL_W'(3);
  localparam logic [REG_SEL_W-1:0] REG_ROW2_COLS01 = REG_SEL_W'(4);
  localparam logic [REG_SEL_W-1:0] REG_ROW2_COLS23 = REG_SEL_W'(5);
  localparam logic [REG_SEL_W-1:0] REG_ROW3_COLS01 = REG_SEL_W'(6);
  localparam logic [REG_SEL_W-1:0] REG_ROW3_COLS23 = REG_SEL_W'(7);

  localparam word_t Q16_ONE  = 32'sh0001_0000;
  localparam word_t Q16_ZERO = 32'sh0000_0000;
  localparam word_t SAT_MAX  = 32'sh7FFF_FFFF;
  localparam word_t SAT_MIN  = 32'sh8000_0000;

  typedef struct packed {
    logic adv;   // pipeline moves this cycle
    logic load;  // final-sum stage holds a live request
  } merge_ctl_t;

endpackage

// ----- rtl/matrix4_vector_transform.sv -----
// 4x4 matrix times homogeneous vector in signed Q16.16. Each accepted request
// (in_x, in_y, in_z, in_w) yields one result: row r of the matrix dotted with
// the vector, summed exactly, shifted right by 16 (floor), clamped to signed
// 32 bits, with out_saturated[r] set when row r was clamped. One request is
// taken every cycle while out_stall holds no finished result; each one goes
// through multiply, pair add, final add and saturate into the output register.
// The rate is set by the four row lanes, each with four 32x32 multipliers of
// their own, so all sixteen products of a vector are formed in the same cycle.
// Coefficients live in eight 64-bit registers (two Q16.16 values each, lower
// column in the low half) written through the cfg_ port, which is always
// ready; indexes beyond seven are dropped. Reset loads the identity matrix.
// Writes are meant for an idle block. out_stall holds the whole pipeline.
module matrix4_vector_transform (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  m4vt_pkg::word_t                   in_x,
  input  m4vt_pkg::word_t                   in_y,
  input  m4vt_pkg::word_t                   in_z,
  input  m4vt_pkg::word_t                   in_w,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output m4vt_pkg::word_t                   out_x,
  output m4vt_pkg::word_t                   out_y,
  output m4vt_pkg::word_t                   out_z,
  output m4vt_pkg::word_t                   out_w,
  output logic [m4vt_pkg::NUM_LANES-1:0]    out_saturated,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [m4vt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  m4vt_pkg::coef_reg_t               cfg_data
);
  import m4vt_pkg::*;

  coef_reg_t             coef_r [NUM_REGS];
  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH-1:0] vld_nxt;
  logic                  adv;
  merge_ctl_t            mctl;
  word_t                 vec [NUM_COLS];
  sum_t                  lane_sum [NUM_LANES];
  word_t                 res [NUM_LANES];
  logic                  cfg_hit;

  // ---------------------------------------------------------------------------
  // Coefficient registers. Always ready; an index past the map is ignored.
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index < CFG_IDX_W'(NUM_REGS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // identity
      coef_r[REG_ROW0_COLS01] <= {Q16_ZERO, Q16_ONE};
      coef_r[REG_ROW0_COLS23] <= {Q16_ZERO, Q16_ZERO};
      coef_r[REG_ROW1_COLS01] <= {Q16_ONE,  Q16_ZERO};
      coef_r[REG_ROW1_COLS23] <= {Q16_ZERO, Q16_ZERO};
      coef_r[REG_ROW2_COLS01] <= {Q16_ZERO, Q16_ZERO};
      coef_r[REG_ROW2_COLS23] <= {Q16_ZERO, Q16_ONE};
      coef_r[REG_ROW3_COLS01] <= {Q16_ZERO, Q16_ZERO};
      coef_r[REG_ROW3_COLS23] <= {Q16_ONE,  Q16_ZERO};
    end else if (cfg_hit) begin
      coef_r[cfg_index[REG_SEL_W-1:0]] <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. All stages move together; the only hold is a result
  // sitting in the output register while the consumer stalls. Bubbles behind
  // it keep flowing only when the pipe moves, which costs nothing at full rate.
  // ---------------------------------------------------------------------------
  assign adv      = ~(vld_r[PIPE_DEPTH-1] & out_stall);
  assign in_stall = ~adv;
  assign vld_nxt  = adv ? {vld_r[PIPE_DEPTH-2:0], in_valid} : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign mctl.adv  = adv;
  assign mctl.load = vld_r[PIPE_DEPTH-2];

  // ---------------------------------------------------------------------------
  // Datapath: one lane per matrix row, then the saturating merge stage.
  // ---------------------------------------------------------------------------
  assign vec[0] = in_x;
  assign vec[1] = in_y;
  assign vec[2] = in_z;
  assign vec[3] = in_w;

  for (genvar r = 0; r < NUM_LANES; r++) begin : g_lane
    m4vt_lane u_lane (
      .clk    (clk),
      .adv    (adv),
      .cols01 (coef_r[2*r]),
      .cols23 (coef_r[2*r+1]),
      .vec    (vec),
      .sum    (lane_sum[r])
    );
  end

  m4vt_merge u_merge (
    .clk (clk),
    .ctl (mctl),
    .sum (lane_sum),
    .res (res),
    .sat (out_saturated)
  );

  assign out_valid = vld_r[PIPE_DEPTH-1];
  assign out_x     = res[0];
  assign out_y     = res[1];
  assign out_z     = res[2];
  assign out_w     = res[3];

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------

  // a request that meets no stall along the way reaches out_valid
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 4) && $past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1) &&
     $past(in_valid && !in_stall, PIPE_DEPTH) && $past(!in_stall, 3) &&
     $past(!in_stall, 2) && $past(!in_stall, 1)) |-> out_valid)
    else $error("request lost in pipeline");

  // a flagged component must hold one of the clamp values
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (!out_saturated[0] || out_x == SAT_MAX || out_x == SAT_MIN) &&
      (!out_saturated[1] || out_y == SAT_MAX || out_y == SAT_MIN) &&
      (!out_saturated[2] || out_z == SAT_MAX || out_z == SAT_MIN) &&
      (!out_saturated[3] || out_w == SAT_MAX || out_w == SAT_MIN))
    else $error("saturation flag without clamp value");

  // an in-range write lands in the addressed register
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> coef_r[$past(cfg_index[REG_SEL_W-1:0])] == $past(cfg_data))
    else $error("coefficient write lost");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

// ----- rtl/m4vt_lane.sv -----
module m4vt_lane (
  input  logic               clk,
  input  logic               adv,
  input  m4vt_pkg::coef_reg_t cols01,
  input  m4vt_pkg::coef_reg_t cols23,
  input  m4vt_pkg::word_t    vec [m4vt_pkg::NUM_COLS],
  output m4vt_pkg::sum_t     sum
);
  import m4vt_pkg::*;

  word_t                    coef   [NUM_COLS];
  logic signed [PROD_W-1:0] prod_r [NUM_COLS];
  logic signed [PAIR_W-1:0] pair_r [NUM_PAIRS];
  sum_t                     sum_r;

  assign coef[0] = cols01[WORD_W-1:0];
  assign coef[1] = cols01[COEF_REG_W-1:WORD_W];
  assign coef[2] = cols23[WORD_W-1:0];
  assign coef[3] = cols23[COEF_REG_W-1:WORD_W];

  // exact signed sum: products, then pair sums, then total
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        prod_r[c] <= PROD_W'(coef[c]) * PROD_W'(vec[c]);
      end
      for (int p = 0; p < NUM_PAIRS; p++) begin
        pair_r[p] <= PAIR_W'(prod_r[2*p]) + PAIR_W'(prod_r[2*p+1]);
      end
      sum_r <= SUM_W'(pair_r[0]) + SUM_W'(pair_r[1]);
    end
  end

  assign sum = sum_r;

endmodule

// ----- rtl/m4vt_merge.sv -----
module m4vt_merge (
  input  logic                 clk,
  input  m4vt_pkg::merge_ctl_t ctl,
  input  m4vt_pkg::sum_t       sum [m4vt_pkg::NUM_LANES],
  output m4vt_pkg::word_t      res [m4vt_pkg::NUM_LANES],
  output logic [m4vt_pkg::NUM_LANES-1:0] sat
);
  import m4vt_pkg::*;

  localparam int TOP_LSB = Q_SHIFT + WORD_W - 1;

  word_t                res_nxt [NUM_LANES];
  word_t                res_r   [NUM_LANES];
  logic [NUM_LANES-1:0] sat_nxt;
  logic [NUM_LANES-1:0] sat_r;
  logic [NUM_LANES-1:0] fits;

  // sum >>> 16 fits in 32 bits when everything from bit 47 up is sign copy
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      fits[i]    = (&sum[i][SUM_W-1:TOP_LSB]) | ~(|sum[i][SUM_W-1:TOP_LSB]);
      sat_nxt[i] = ~fits[i];
      if (fits[i]) begin
        res_nxt[i] = sum[i][Q_SHIFT +: WORD_W];
      end else if (sum[i][SUM_W-1]) begin
        res_nxt[i] = SAT_MIN;
      end else begin
        res_nxt[i] = SAT_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv && ctl.load) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign res = res_r;
  assign sat = sat_r;

endmodule

// ----- bench/matrix4_vector_transform_test.sv -----
`timescale 1ns / 1ps

module matrix4_vector_transform_test;
  import m4vt_pkg::*;

  localparam int MAX_IDLE         = 19;
  localparam int RANDOM_PHASES    = 8;
  localparam int ITEMS_PER_PHASE  = 92;
  localparam int WATCHDOG_LIMIT   = 1000;
  localparam int SHOWN_MISMATCHES = 10;
  // pipeline depth plus margin, waited out before config writes and at the end
  localparam int SETTLE_CYCLES    = PIPE_DEPTH + 4;

  // index with every bit set: past the register map, so the write must be dropped
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_IDX = {CFG_IDX_W{1'b1}};

  // how far random Q16.16 values reach
  typedef enum int unsigned {
    SPREAD_NEAR,   // within +/-32.0
    SPREAD_MIXED,  // extremes, unit values, zero, near and full-range words
    SPREAD_WIDE    // any 32-bit word
  } spread_t;

  typedef struct packed {
    word_t      x;
    word_t      y;
    word_t      z;
    word_t      w;
    logic [4:0] gap;  // idle cycles before the request is presented
  } vertex_req_t;

  typedef struct packed {
    word_t                x;
    word_t                y;
    word_t                z;
    word_t                w;
    logic [NUM_LANES-1:0] sat;
  } vertex_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic  in_valid = 1'b0;
  logic  in_stall;
  word_t in_x = '0;
  word_t in_y = '0;
  word_t in_z = '0;
  word_t in_w = '0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  word_t                out_x;
  word_t                out_y;
  word_t                out_z;
  word_t                out_w;
  logic [NUM_LANES-1:0] out_saturated;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  coef_reg_t            cfg_data = '0;

  matrix4_vector_transform dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_x         (in_x),
    .in_y         (in_y),
    .in_z         (in_z),
    .in_w         (in_w),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .out_w        (out_w),
    .out_saturated(out_saturated),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // Our own copy of the coefficient registers, same packing as the block.
  coef_reg_t coef_regs [NUM_REGS];

  vertex_req_t    pending_vertices [$];
  vertex_result_t expected_results [$];

  // idle-free stretches on either side, chosen per phase
  bit src_calm  = 1'b0;
  bit sink_calm = 1'b0;

  int mismatches   = 0;
  int n_vertices   = 0;
  int n_results    = 0;
  int n_clamped    = 0;
  int n_reg_writes = 0;
  int n_settings   = 0;
  int sink_hold    = 0;
  int idle_cycles  = 0;

  vertex_req_t    next_req;
  vertex_result_t seen;
  vertex_result_t want;

  function automatic coef_reg_t coef_pair(input word_t lo, input word_t hi);
    return {hi, lo};
  endfunction

  // Exact 4x4 product: 64-bit products summed at 66 bits, floor shift, clamp.
  function automatic vertex_result_t transform_vertex(input word_t vx, input word_t vy,
                                                      input word_t vz, input word_t vw);
    word_t          vec [NUM_COLS];
    coef_reg_t      pair;
    word_t          coef;
    longint         prod;
    sum_t           acc;
    sum_t           scaled;
    word_t          lane [NUM_LANES];
    vertex_result_t res;
    vec[0] = vx;
    vec[1] = vy;
    vec[2] = vz;
    vec[3] = vw;
    res.sat = '0;
    for (int r = 0; r < NUM_LANES; r++) begin
      acc = '0;
      for (int c = 0; c < NUM_COLS; c++) begin
        pair = coef_regs[r * NUM_PAIRS + c / 2];
        coef = (c % 2 != 0) ? pair[WORD_W +: WORD_W] : pair[0 +: WORD_W];
        prod = longint'(coef) * longint'(vec[c]);
        acc  = acc + sum_t'(prod);
      end
      scaled = acc >>> Q_SHIFT;
      if (scaled > sum_t'(SAT_MAX)) begin
        lane[r]    = SAT_MAX;
        res.sat[r] = 1'b1;
      end else if (scaled < sum_t'(SAT_MIN)) begin
        lane[r]    = SAT_MIN;
        res.sat[r] = 1'b1;
      end else begin
        lane[r] = word_t'(scaled);
      end
    end
    res.x = lane[0];
    res.y = lane[1];
    res.z = lane[2];
    res.w = lane[3];
    return res;
  endfunction

  function automatic word_t rand_q16(input spread_t spread);
    logic signed [21:0] near;
    near = 22'($urandom);
    case (spread)
      SPREAD_NEAR: return {{(WORD_W - 22){near[21]}}, near};
      SPREAD_WIDE: return word_t'($urandom);
      default: begin
        case ($urandom_range(0, 7))
          0:       return SAT_MAX;
          1:       return SAT_MIN;
          2:       return Q16_ONE;
          3:       return -Q16_ONE;
          4:       return Q16_ZERO;
          5, 6:    return {{(WORD_W - 22){near[21]}}, near};
          default: return word_t'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic queue_vertex(input word_t vx, input word_t vy, input word_t vz,
                              input word_t vw);
    vertex_req_t req;
    req.x   = vx;
    req.y   = vy;
    req.z   = vz;
    req.w   = vw;
    req.gap = src_calm ? 5'd0 : 5'($urandom_range(0, MAX_IDLE));
    pending_vertices.push_back(req);
  endtask

  // One register write; only called with nothing in flight.
  task automatic load_coef_reg(input logic [CFG_IDX_W-1:0] idx, input coef_reg_t value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx < NUM_REGS)
      coef_regs[idx[REG_SEL_W-1:0]] = value;
    n_reg_writes++;
    @(negedge clk);
  endtask

  // write to one of the mapped registers
  task automatic load_row_reg(input logic [REG_SEL_W-1:0] sel, input coef_reg_t value);
    load_coef_reg({1'b0, sel}, value);
  endtask

  task automatic load_random_matrix(input spread_t spread);
    for (int k = 0; k < NUM_REGS; k++)
      load_coef_reg(CFG_IDX_W'(k), coef_pair(rand_q16(spread), rand_q16(spread)));
    // sometimes also poke the unmapped upper half of the index space
    if ($urandom_range(0, 1) != 0)
      load_coef_reg(CFG_IDX_W'(NUM_REGS + $urandom_range(0, NUM_REGS - 1)),
                    {$urandom, $urandom});
  endtask

  // Sender holds off until every expected result is back, then the pipe settles.
  task automatic wait_idle();
    while (pending_vertices.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: pops the next request once the current one is taken,
  // honoring its idle gap. A stalled request keeps valid and payload as they are.
  // The prediction is made at the edge where the request is accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(transform_vertex(in_x, in_y, in_z, in_w));
        n_vertices++;
      end
      if (!(in_valid && in_stall)) begin
        if (pending_vertices.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_vertices[0].gap != 0) begin
          pending_vertices[0].gap = pending_vertices[0].gap - 5'd1;
          in_valid <= 1'b0;
        end else begin
          next_req = pending_vertices.pop_front();
          in_valid <= 1'b1;
          in_x     <= next_req.x;
          in_y     <= next_req.y;
          in_z     <= next_req.z;
          in_w     <= next_req.w;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks each accepted result against the oldest prediction,
  // then draws how many cycles to stall before taking the next one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      sink_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen.x   = out_x;
        seen.y   = out_y;
        seen.z   = out_z;
        seen.w   = out_w;
        seen.sat = out_saturated;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("result %0d with no request pending: x=%h y=%h z=%h w=%h sat=%b",
                     n_results, seen.x, seen.y, seen.z, seen.w, seen.sat);
        end else begin
          want = expected_results.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
              $display({"result %0d mismatch: exp x=%h y=%h z=%h w=%h sat=%b,",
                        " got x=%h y=%h z=%h w=%h sat=%b"},
                       n_results, want.x, want.y, want.z, want.w, want.sat,
                       seen.x, seen.y, seen.z, seen.w, seen.sat);
          end
        end
        n_results++;
        if (out_saturated != '0)
          n_clamped++;
        sink_hold = sink_calm ? 0 : $urandom_range(0, MAX_IDLE);
      end else if (sink_hold != 0) begin
        sink_hold--;
      end
      out_stall <= (sink_hold != 0);
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("no handshake for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    spread_t vec_spread;

    // matrix after reset: identity
    foreach (coef_regs[k])
      coef_regs[k] = '0;
    coef_regs[REG_ROW0_COLS01] = coef_pair(Q16_ONE, Q16_ZERO);
    coef_regs[REG_ROW1_COLS01] = coef_pair(Q16_ZERO, Q16_ONE);
    coef_regs[REG_ROW2_COLS23] = coef_pair(Q16_ONE, Q16_ZERO);
    coef_regs[REG_ROW3_COLS23] = coef_pair(Q16_ZERO, Q16_ONE);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Identity: extremes pass straight through, none clamped. Back to back.
    src_calm  = 1'b1;
    sink_calm = 1'b1;
    queue_vertex(Q16_ZERO, Q16_ZERO, Q16_ZERO, Q16_ZERO);
    queue_vertex(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
    queue_vertex(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
    queue_vertex(word_t'(-1), word_t'(-1), word_t'(-1), word_t'(-1));
    queue_vertex(Q16_ONE, -Q16_ONE, SAT_MAX, SAT_MIN);
    queue_vertex(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_F0F0, 32'shF0F0_0F0F);
    wait_idle();
    n_settings++;

    // Extreme coefficients: largest sums of either sign, which clamp.
    // Row 2 all most-negative: min * min in every column is the largest sum.
    src_calm  = 1'b0;
    sink_calm = 1'b0;
    load_row_reg(REG_ROW0_COLS01, coef_pair(SAT_MAX, SAT_MAX));
    load_row_reg(REG_ROW0_COLS23, coef_pair(SAT_MAX, SAT_MAX));
    load_row_reg(REG_ROW1_COLS01, coef_pair(SAT_MAX, SAT_MIN));
    load_row_reg(REG_ROW1_COLS23, coef_pair(SAT_MAX, SAT_MIN));
    load_row_reg(REG_ROW2_COLS01, coef_pair(SAT_MIN, SAT_MIN));
    load_row_reg(REG_ROW2_COLS23, coef_pair(SAT_MIN, SAT_MIN));
    load_row_reg(REG_ROW3_COLS01, coef_pair(SAT_MIN, SAT_MAX));
    load_row_reg(REG_ROW3_COLS23, coef_pair(word_t'(-1), Q16_ONE));
    // out-of-map index: must leave the matrix alone
    load_coef_reg(UNMAPPED_IDX, '0);
    queue_vertex(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
    queue_vertex(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
    queue_vertex(Q16_ZERO, Q16_ZERO, Q16_ZERO, Q16_ZERO);
    queue_vertex(SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN);
    queue_vertex(Q16_ONE, Q16_ONE, Q16_ONE, Q16_ONE);
    queue_vertex(word_t'(-1), word_t'(-1), word_t'(-1), word_t'(-1));
    wait_idle();
    n_settings++;

    // Rounding and clamp edges:
    //   row 0 = 2^-16 * x        -> tiny negative rounds down to -1 lsb
    //   row 1 = x + 2^-16 * y    -> one lsb over the top clamps, just under does not
    //   row 2 = -x               -> negating the most negative word clamps
    //   row 3 = x - 2^-16 * y    -> one lsb under the bottom clamps
    load_row_reg(REG_ROW0_COLS01, coef_pair(32'sd1, Q16_ZERO));
    load_row_reg(REG_ROW0_COLS23, '0);
    load_row_reg(REG_ROW1_COLS01, coef_pair(Q16_ONE, 32'sd1));
    load_row_reg(REG_ROW1_COLS23, '0);
    load_row_reg(REG_ROW2_COLS01, coef_pair(-Q16_ONE, Q16_ZERO));
    load_row_reg(REG_ROW2_COLS23, '0);
    load_row_reg(REG_ROW3_COLS01, coef_pair(Q16_ONE, word_t'(-1)));
    load_row_reg(REG_ROW3_COLS23, '0);
    queue_vertex(word_t'(-1), Q16_ZERO, Q16_ZERO, Q16_ZERO);
    queue_vertex(32'sd1, Q16_ZERO, Q16_ZERO, Q16_ZERO);
    queue_vertex(SAT_MAX, 32'sd65536, Q16_ZERO, Q16_ZERO);
    queue_vertex(SAT_MAX, 32'sd65535, Q16_ZERO, Q16_ZERO);
    queue_vertex(SAT_MIN, 32'sd1, Q16_ZERO, Q16_ZERO);
    queue_vertex(SAT_MIN, Q16_ZERO, Q16_ZERO, Q16_ZERO);
    wait_idle();
    n_settings++;

    // Random matrices, each followed by a batch of random vectors. Every phase
    // drains fully before the next set of coefficient writes.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_random_matrix(spread_t'($urandom_range(0, 2)));
      src_calm  = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);
      repeat (ITEMS_PER_PHASE) begin
        vec_spread = spread_t'($urandom_range(0, 2));
        queue_vertex(rand_q16(vec_spread), rand_q16(vec_spread),
                     rand_q16(vec_spread), rand_q16(vec_spread));
      end
      wait_idle();
      n_settings++;
    end

    $display("%0d vectors transformed under %0d matrix settings (%0d register writes)",
             n_vertices, n_settings, n_reg_writes);
    $display("%0d results had a clamped lane, %0d mismatches", n_clamped, mismatches);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
